// ----- hw/rtl/aegis_pkg.sv -----
// Package for the AEGIS-128L engine: payload structs, opcodes, state
// constants and the AES round function. Used by every file in hw/rtl.
package aegis_pkg;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_ABSORB   = 3'd1,
    OP_ENCRYPT  = 3'd2,
    OP_DECRYPT  = 3'd3,
    OP_FINALIZE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_KEY_LOW    = 2'd0,
    REG_KEY_HIGH   = 2'd1,
    REG_NONCE_LOW  = 2'd2,
    REG_NONCE_HIGH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] data_word0;
    logic [63:0] data_word1;
    logic [63:0] data_word2;
    logic [63:0] data_word3;
    logic [5:0]  valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word0;
    logic [63:0] out_word1;
    logic [63:0] out_word2;
    logic [63:0] out_word3;
    logic        tag_match;
  } out_item_t;

  // Message pair fed to one state update
  typedef struct packed {
    logic [127:0] m0;
    logic [127:0] m1;
  } upd_msg_t;

  localparam logic [127:0] C0 = 128'h6279e99059372215_0d08050302010100;
  localparam logic [127:0] C1 = 128'hdd28b57342311120_f12fc26d55183ddb;
  localparam logic [3:0] INIT_ROUNDS  = 4'd10;
  localparam logic [3:0] FINAL_ROUNDS = 4'd7;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES round on little-endian byte vectors: byte k sits at [8k+7:8k]
  function automatic logic [127:0] aes_enc_round(input logic [127:0] din,
                                                 input logic [127:0] rk);
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[din[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int r = 0; r < 4; r++) begin
        o[8*(4*c+r) +: 8] = t[4*c+r] ^ all ^ xt(t[4*c+r] ^ t[4*c+((r+1)%4)])
                            ^ rk[8*(4*c+r) +: 8];
      end
    end
    aes_enc_round = o;
  endfunction

endpackage

// ----- hw/rtl/aegis_update.sv -----
// One AEGIS-128L state update: eight parallel AES rounds on the state.
// Depends on aegis_pkg for aes_enc_round and upd_msg_t.
module aegis_update (
  input  logic [1023:0]      s_in,
  input  aegis_pkg::upd_msg_t msg,
  output logic [1023:0]      s_out
);

  logic [127:0] blk [8];
  logic [127:0] rk  [8];

  // Split state into blocks and mix the message into blocks 0 and 4
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk[i] = s_in[128*i +: 128];
    end
    for (int i = 0; i < 8; i++) begin
      rk[i] = blk[i];
    end
    rk[0] = blk[0] ^ msg.m0;
    rk[4] = blk[4] ^ msg.m1;
    for (int i = 0; i < 8; i++) begin
      s_out[128*i +: 128] = aegis_pkg::aes_enc_round(blk[(i + 7) % 8], rk[i]);
    end
  end

endmodule

// ----- hw/rtl/aegis128l_aead_engine_top.sv -----
// AEGIS-128L AEAD engine top: sequencer, state register and handshakes.
// Depends on aegis_pkg and aegis_update.
// Throughput: one transaction at a time; the shared update unit runs one
// state update per cycle, so start takes 10 update passes and finalize 7.
// Reset (rst_n low, synchronous) clears the state, key/nonce and control.
module aegis128l_aead_engine_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  aegis_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aegis_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [1023:0]        cs_r, cs_nxt;
  logic [63:0]          key_lo_r, key_hi_r, nonce_lo_r, nonce_hi_r;
  logic [3:0]           cnt_r, cnt_nxt;
  aegis_pkg::upd_msg_t  msg_r, msg_nxt;
  aegis_pkg::out_item_t res_r, res_nxt;
  logic                 fin_r, fin_nxt;
  logic [127:0]         exp_r, exp_nxt;
  logic [1023:0]        upd_out;
  logic                 acc;

  aegis_update u_upd (.s_in(cs_r), .msg(msg_r), .s_out(upd_out));

  // Hold out_valid low while the tag is formed
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT) && !fin_r;
  assign out_data  = res_r;
  assign acc       = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0; key_hi_r <= '0; nonce_lo_r <= '0; nonce_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        aegis_pkg::REG_KEY_LOW:   key_lo_r   <= cfg_wdata;
        aegis_pkg::REG_KEY_HIGH:  key_hi_r   <= cfg_wdata;
        aegis_pkg::REG_NONCE_LOW: nonce_lo_r <= cfg_wdata;
        default:                  nonce_hi_r <= cfg_wdata;
      endcase
    end
  end

  // Sequencer: decode the transaction, then iterate the update unit; an unknown opcode goes straight to ST_OUT
  always_comb begin
    logic [255:0] blk, z, res;
    logic [5:0]   n;
    logic [127:0] key, nonce, tag, st2;
    state_nxt = state_r;
    cs_nxt    = cs_r;
    cnt_nxt   = cnt_r;
    msg_nxt   = msg_r;
    res_nxt   = res_r;
    fin_nxt   = fin_r;
    exp_nxt   = exp_r;
    key   = {key_hi_r, key_lo_r};
    nonce = {nonce_hi_r, nonce_lo_r};
    n     = (in_data.valid_bytes > 6'd32) ? 6'd32 : in_data.valid_bytes;
    blk   = {in_data.data_word3, in_data.data_word2,
             in_data.data_word1, in_data.data_word0};
    for (int k = 0; k < 32; k++) begin
      if (6'(k) >= n) blk[8*k +: 8] = 8'h00;
    end
    z = {cs_r[256 +: 128] ^ cs_r[640 +: 128] ^ (cs_r[768 +: 128] & cs_r[896 +: 128]),
         cs_r[768 +: 128] ^ cs_r[128 +: 128] ^ (cs_r[256 +: 128] & cs_r[384 +: 128])};
    res = blk ^ z;
    for (int k = 0; k < 32; k++) begin
      if (6'(k) >= n) res[8*k +: 8] = 8'h00;
    end
    st2 = cs_r[256 +: 128] ^ {in_data.data_word1, in_data.data_word0};
    tag = cs_r[0 +: 128] ^ cs_r[128 +: 128] ^ cs_r[256 +: 128] ^ cs_r[384 +: 128]
        ^ cs_r[512 +: 128] ^ cs_r[640 +: 128] ^ cs_r[768 +: 128];
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          res_nxt   = '0;
          fin_nxt   = 1'b0;
          exp_nxt   = {in_data.data_word3, in_data.data_word2};
          state_nxt = ST_RUN;
          cnt_nxt   = 4'd1;
          case (in_data.operation)
            aegis_pkg::OP_START: begin
              cs_nxt  = {key ^ aegis_pkg::C0, key ^ aegis_pkg::C1,
                         key ^ aegis_pkg::C0, key ^ nonce, aegis_pkg::C1,
                         aegis_pkg::C0, aegis_pkg::C1, key ^ nonce};
              msg_nxt = '{m0: nonce, m1: key};
              cnt_nxt = aegis_pkg::INIT_ROUNDS;
            end
            aegis_pkg::OP_ABSORB: msg_nxt = '{m0: blk[127:0], m1: blk[255:128]};
            aegis_pkg::OP_ENCRYPT: begin
              msg_nxt = '{m0: blk[127:0], m1: blk[255:128]};
              res_nxt = '{out_word0: res[63:0], out_word1: res[127:64],
                          out_word2: res[191:128], out_word3: res[255:192],
                          tag_match: 1'b0};
            end
            aegis_pkg::OP_DECRYPT: begin
              msg_nxt = '{m0: res[127:0], m1: res[255:128]};
              res_nxt = '{out_word0: res[63:0], out_word1: res[127:64],
                          out_word2: res[191:128], out_word3: res[255:192],
                          tag_match: 1'b0};
            end
            aegis_pkg::OP_FINALIZE: begin
              msg_nxt = '{m0: st2, m1: st2};
              cnt_nxt = aegis_pkg::FINAL_ROUNDS;
              fin_nxt = 1'b1;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_RUN: begin
        // Advance one update per cycle
        cs_nxt  = upd_out;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd1) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (fin_r) begin
          res_nxt = '{out_word0: tag[63:0], out_word1: tag[127:64],
                      out_word2: '0, out_word3: '0, tag_match: (tag == exp_r)};
          fin_nxt = 1'b0;
        end else if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Register sequencer state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cs_r    <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cs_r    <= cs_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
    res_r <= res_nxt;
    exp_r <= exp_nxt;
  end

  // Assertions
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_cnt_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (cnt_r != 4'd0)) else $error("run with zero count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !fin_r) |=> ($stable(out_data) && out_valid))
    else $error("result dropped");

endmodule
